// File: sv/urp_pkg.sv
// shared types and constants for the undo record parser
package urp_pkg;

   localparam int unsigned COIN_BYTES = 46;

   // command codes of an input transaction
   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // parser phases
   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_TXC  = 4'd1;
   localparam logic [3:0] PH_CC   = 4'd2;
   localparam logic [3:0] PH_VAL  = 4'd3;
   localparam logic [3:0] PH_HGT  = 4'd4;
   localparam logic [3:0] PH_CB   = 4'd5;
   localparam logic [3:0] PH_SP   = 4'd6;
   localparam logic [3:0] PH_HASH = 4'd7;
   localparam logic [3:0] PH_FIN  = 4'd8;

   // result kinds
   localparam logic [2:0] KIND_TX_COUNT   = 3'd0;
   localparam logic [2:0] KIND_COIN_COUNT = 3'd1;
   localparam logic [2:0] KIND_VALUE      = 3'd2;
   localparam logic [2:0] KIND_HEIGHT     = 3'd3;
   localparam logic [2:0] KIND_FLAGS      = 3'd4;
   localparam logic [2:0] KIND_HASH_WORD  = 3'd5;
   localparam logic [2:0] KIND_DONE       = 3'd6;
   localparam logic [2:0] KIND_ERROR      = 3'd7;

   // error codes
   localparam logic [2:0] ERR_NONE            = 3'd0;
   localparam logic [2:0] ERR_TOO_SHORT       = 3'd1;
   localparam logic [2:0] ERR_TX_COUNT        = 3'd2;
   localparam logic [2:0] ERR_TRUNC_COUNT     = 3'd3;
   localparam logic [2:0] ERR_COIN_COUNT      = 3'd4;
   localparam logic [2:0] ERR_TRUNC_COINS     = 3'd5;

   // csr register indexes
   localparam logic REG_MAX_COUNT = 1'b0;

   // one queued input transaction
   typedef struct packed {
      logic        cmd;
      logic [7:0]  data_byte;
      logic [31:0] record_length;
   } entry_type;

   // queue head as seen by the parser
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

// File: sv/urp_front.sv
// input front end: accepts transactions into a two-entry queue
module urp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  logic [7:0]          req_data_byte,
   input  logic [31:0]         req_record_length,
   output urp_pkg::head_type   head,
   input  logic                pop
);
   import urp_pkg::*;

   entry_type   entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        do_pop;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && (count_ff != 2'd0);

   assign head.valid = (count_ff != 2'd0);
   assign head.entry = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{cmd: req_cmd, data_byte: req_data_byte,
                                  record_length: req_record_length};
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd0 && !push |=> count_ff == 2'd0)
      else $error("queue count moved without a push");

endmodule

// File: sv/urp_back.sv
// parser back end: decodes queued bytes and holds the result register
module urp_back (
   input  logic                clock,
   input  logic                reset,
   input  urp_pkg::head_type   head,
   output logic                pop,
   input  logic [15:0]         max_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_kind,
   output logic [63:0]         rsp_data,
   output logic [1:0]          rsp_hash_word_index,
   output logic [15:0]         rsp_tx_index,
   output logic [15:0]         rsp_coin_index,
   output logic [2:0]          rsp_error_code
);
   import urp_pkg::*;

   localparam logic [5:0] COIN_MULT = 6'(COIN_BYTES);

   logic [3:0]  phase_ff, phase_in;
   logic [5:0]  fbc_ff, fbc_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] length_ff, length_in;
   logic [15:0] tx_total_ff, tx_total_in;
   logic [15:0] tx_pos_ff, tx_pos_in;
   logic [15:0] coin_total_ff, coin_total_in;
   logic [15:0] coin_pos_ff, coin_pos_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff;
   logic [63:0] rsp_data_ff;
   logic [1:0]  rsp_hwi_ff;
   logic [15:0] rsp_tx_ff;
   logic [15:0] rsp_coin_ff;
   logic [2:0]  rsp_err_ff;

   logic        advance;
   logic        emit;
   logic [2:0]  e_kind;
   logic [63:0] e_data;
   logic [1:0]  e_hwi;
   logic [15:0] e_tx;
   logic [15:0] e_coin;
   logic [2:0]  e_err;

   logic [7:0]  b;
   logic [63:0] acc_take;
   logic [5:0]  fbc_take;
   logic [31:0] off_take;
   logic [31:0] v32;
   logic        over_max;
   logic [21:0] coin_span;
   logic [32:0] coin_end;
   logic [15:0] tx_next;
   logic [15:0] coin_next;

   assign advance = head.valid && (!rsp_valid_ff || rsp_ready);
   assign pop     = advance;

   assign b         = head.entry.data_byte;
   assign acc_take  = acc_ff | ({56'd0, b} << {fbc_ff[2:0], 3'b000});
   assign fbc_take  = fbc_ff + 6'd1;
   assign off_take  = offset_ff + 32'd1;
   assign v32       = acc_take[31:0];
   assign over_max  = v32 > {16'd0, max_count};
   assign coin_span = {6'd0, v32[15:0]} * {16'd0, COIN_MULT};
   assign coin_end  = {1'b0, off_take} + {11'd0, coin_span};
   assign tx_next   = tx_pos_ff + 16'd1;
   assign coin_next = coin_pos_ff + 16'd1;

   always_comb begin
      phase_in      = phase_ff;
      fbc_in        = fbc_ff;
      acc_in        = acc_ff;
      offset_in     = offset_ff;
      length_in     = length_ff;
      tx_total_in   = tx_total_ff;
      tx_pos_in     = tx_pos_ff;
      coin_total_in = coin_total_ff;
      coin_pos_in   = coin_pos_ff;
      emit   = 1'b0;
      e_kind = KIND_ERROR;
      e_data = 64'd0;
      e_hwi  = 2'd0;
      e_tx   = tx_pos_ff;
      e_coin = coin_pos_ff;
      e_err  = ERR_NONE;

      if (head.entry.cmd == CMD_BEGIN) begin
         length_in     = head.entry.record_length;
         offset_in     = 32'd0;
         tx_total_in   = 16'd0;
         tx_pos_in     = 16'd0;
         coin_total_in = 16'd0;
         coin_pos_in   = 16'd0;
         phase_in      = PH_TXC;
         fbc_in        = 6'd0;
         acc_in        = 64'd0;
         if (head.entry.record_length < 32'd4) begin
            phase_in = PH_IDLE;
            emit     = 1'b1;
            e_tx     = 16'd0;
            e_coin   = 16'd0;
            e_err    = ERR_TOO_SHORT;
         end
      end else begin
         case (phase_ff)
            PH_TXC: begin
               acc_in    = acc_take;
               fbc_in    = fbc_take;
               offset_in = off_take;
               if (fbc_take == 6'd4) begin
                  emit = 1'b1;
                  if (over_max) begin
                     phase_in = PH_IDLE;
                     e_err    = ERR_TX_COUNT;
                  end else begin
                     tx_total_in = v32[15:0];
                     phase_in    = (v32 == 32'd0) ? PH_FIN : PH_CC;
                     fbc_in      = 6'd0;
                     acc_in      = 64'd0;
                     e_kind      = KIND_TX_COUNT;
                     e_data      = {32'd0, v32};
                  end
               end
            end
            PH_CC: begin
               if (fbc_ff == 6'd0 && ({1'b0, offset_ff} + 33'd4) > {1'b0, length_ff}) begin
                  emit     = 1'b1;
                  phase_in = PH_IDLE;
                  e_err    = ERR_TRUNC_COUNT;
               end else begin
                  acc_in    = acc_take;
                  fbc_in    = fbc_take;
                  offset_in = off_take;
                  if (fbc_take == 6'd4) begin
                     emit = 1'b1;
                     if (over_max) begin
                        phase_in = PH_IDLE;
                        e_err    = ERR_COIN_COUNT;
                     end else if (coin_end > {1'b0, length_ff}) begin
                        phase_in = PH_IDLE;
                        e_err    = ERR_TRUNC_COINS;
                     end else begin
                        coin_total_in = v32[15:0];
                        coin_pos_in   = 16'd0;
                        e_kind        = KIND_COIN_COUNT;
                        e_data        = {32'd0, v32};
                        e_coin        = 16'd0;
                        fbc_in        = 6'd0;
                        acc_in        = 64'd0;
                        if (v32 == 32'd0) begin
                           tx_pos_in = tx_next;
                           phase_in  = (tx_next >= tx_total_ff) ? PH_FIN : PH_CC;
                        end else begin
                           phase_in = PH_VAL;
                        end
                     end
                  end
               end
            end
            PH_VAL: begin
               acc_in    = acc_take;
               fbc_in    = fbc_take;
               offset_in = off_take;
               if (fbc_take == 6'd8) begin
                  emit     = 1'b1;
                  e_kind   = KIND_VALUE;
                  e_data   = acc_take;
                  phase_in = PH_HGT;
                  fbc_in   = 6'd0;
                  acc_in   = 64'd0;
               end
            end
            PH_HGT: begin
               acc_in    = acc_take;
               fbc_in    = fbc_take;
               offset_in = off_take;
               if (fbc_take == 6'd4) begin
                  emit     = 1'b1;
                  e_kind   = KIND_HEIGHT;
                  e_data   = acc_take;
                  phase_in = PH_CB;
                  fbc_in   = 6'd0;
                  acc_in   = 64'd0;
               end
            end
            PH_CB: begin
               offset_in = off_take;
               phase_in  = PH_SP;
               acc_in    = {63'd0, (b != 8'd0)};
            end
            PH_SP: begin
               offset_in = off_take;
               emit      = 1'b1;
               e_kind    = KIND_FLAGS;
               e_data    = acc_ff | {62'd0, (b != 8'd0), 1'b0};
               phase_in  = PH_HASH;
               fbc_in    = 6'd0;
               acc_in    = 64'd0;
            end
            PH_HASH: begin
               acc_in    = acc_take;
               fbc_in    = fbc_take;
               offset_in = off_take;
               if (fbc_take[2:0] == 3'd0) begin
                  emit   = 1'b1;
                  e_kind = KIND_HASH_WORD;
                  e_data = acc_take;
                  e_hwi  = fbc_ff[4:3];
                  acc_in = 64'd0;
                  if (fbc_take >= 6'd32) begin
                     fbc_in = 6'd0;
                     if (coin_next >= coin_total_ff) begin
                        tx_pos_in   = tx_next;
                        coin_pos_in = 16'd0;
                        phase_in    = (tx_next >= tx_total_ff) ? PH_FIN : PH_CC;
                     end else begin
                        coin_pos_in = coin_next;
                        phase_in    = PH_VAL;
                     end
                  end
               end
            end
            PH_FIN: begin
               emit     = 1'b1;
               e_kind   = KIND_DONE;
               e_data   = {32'd0, offset_ff};
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fbc_ff        <= fbc_in;
         acc_ff        <= acc_in;
         offset_ff     <= offset_in;
         length_ff     <= length_in;
         tx_total_ff   <= tx_total_in;
         tx_pos_ff     <= tx_pos_in;
         coin_total_ff <= coin_total_in;
         coin_pos_ff   <= coin_pos_in;
      end
      if (advance && emit) begin
         rsp_kind_ff <= e_kind;
         rsp_data_ff <= e_data;
         rsp_hwi_ff  <= e_hwi;
         rsp_tx_ff   <= e_tx;
         rsp_coin_ff <= e_coin;
         rsp_err_ff  <= e_err;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_data            = rsp_data_ff;
   assign rsp_hash_word_index = rsp_hwi_ff;
   assign rsp_tx_index        = rsp_tx_ff;
   assign rsp_coin_index      = rsp_coin_ff;
   assign rsp_error_code      = rsp_err_ff;

   a_error_has_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_ERROR |-> rsp_err_ff != ERR_NONE)
      else $error("error result without error code");

   a_error_goes_idle: assert property (@(posedge clock) disable iff (reset)
      advance && emit && e_kind == KIND_ERROR |=> phase_ff == PH_IDLE)
      else $error("parser did not stop after error");

   a_hash_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HASH |-> fbc_ff < 6'd32)
      else $error("hash byte count out of range");

endmodule

// File: sv/undo_record_parser.sv
// top level of the undo record parser with its csr port
//
// usage:
//   req_* carries one transaction per handshake: req_cmd low starts a record of
//   req_record_length bytes, req_cmd high delivers the next record byte in
//   req_data_byte. every decoded field (counts, value, height, flags, hash
//   words, done, error) leaves as one rsp_* transaction; most bytes give none.
//   csr_* is an apb-style port; max_count sits at address 0 and caps both the
//   transaction count and each coin count. write it only while the block is idle.
// throughput and data path:
//   one transaction per cycle sustained while rsp_ready stays high. an input
//   transaction is written into the queue, then the parser decodes the queue
//   head into the result register; it takes one byte per cycle unless stalled.
// stalls:
//   a two-entry queue sits between the input side and the parser, and the
//   result register is loaded whenever it is empty or being drained, so while
//   rsp_ready is low the queue still takes up to two transactions.
// reset:
//   synchronous, active high; empties the queue and result register, sets the
//   parser idle (bytes ignored until a begin) and max_count back to 65535
module undo_record_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic         req_cmd,
   input  logic [7:0]   req_data_byte,
   input  logic [31:0]  req_record_length,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_kind,
   output logic [63:0]  rsp_data,
   output logic [1:0]   rsp_hash_word_index,
   output logic [15:0]  rsp_tx_index,
   output logic [15:0]  rsp_coin_index,
   output logic [2:0]   rsp_error_code,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import urp_pkg::*;

   logic [15:0] max_count_ff, max_count_in;
   logic        csr_write;
   head_type    head;
   logic        pop;

   // csr: single register, word address taken from paddr bit 2
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_MAX_COUNT) ? {16'd0, max_count_ff} : 32'd0;

   always_comb begin
      max_count_in = max_count_ff;
      if (csr_write && csr_paddr[2] == REG_MAX_COUNT) begin
         max_count_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff <= 16'hFFFF;
      end else begin
         max_count_ff <= max_count_in;
      end
   end

   // front end: input queue
   urp_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_data_byte     (req_data_byte),
      .req_record_length (req_record_length),
      .head              (head),
      .pop               (pop)
   );

   // back end: byte parser and result register
   urp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .pop                 (pop),
      .max_count           (max_count_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_data            (rsp_data),
      .rsp_hash_word_index (rsp_hash_word_index),
      .rsp_tx_index        (rsp_tx_index),
      .rsp_coin_index      (rsp_coin_index),
      .rsp_error_code      (rsp_error_code)
   );

endmodule

// File: test/tb_undo_record_parser.sv
// testbench for undo_record_parser: random undo records checked against a field-by-field predictor
module tb_undo_record_parser;
   import urp_pkg::*;

   // one decoded field as it leaves the parser
   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] data;
      logic [1:0]  word;
      logic [15:0] tx;
      logic [15:0] coin;
      logic [2:0]  err;
   } parsed_field_type;

   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PRINT_LIMIT = 30;

   logic clock = 1'b0;
   logic reset;

   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [7:0]  req_data_byte;
   logic [31:0] req_record_length;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_kind;
   logic [63:0] rsp_data;
   logic [1:0]  rsp_hash_word_index;
   logic [15:0] rsp_tx_index;
   logic [15:0] rsp_coin_index;
   logic [2:0]  rsp_error_code;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   undo_record_parser u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_data_byte       (req_data_byte),
      .req_record_length   (req_record_length),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_data            (rsp_data),
      .rsp_hash_word_index (rsp_hash_word_index),
      .rsp_tx_index        (rsp_tx_index),
      .rsp_coin_index      (rsp_coin_index),
      .rsp_error_code      (rsp_error_code),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // parser state as the predictor sees it
   logic [15:0] limit_count = 16'hFFFF;
   logic [3:0]  parse_phase = PH_IDLE;
   logic [5:0]  field_bytes = '0;
   logic [63:0] field_acc = '0;
   logic [31:0] bytes_taken = '0;
   logic [31:0] record_len = '0;
   logic [15:0] tx_count_total = '0;
   logic [15:0] tx_at = '0;
   logic [15:0] coin_count_total = '0;
   logic [15:0] coin_at = '0;

   parsed_field_type expected_fields[$];
   logic [7:0]       record_bytes[$];

   int unsigned mismatch_count = 0;
   int unsigned items_sent = 0;
   int unsigned send_limit = 32'hFFFF_FFFF;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned hold_cycles = 0;

   // ---------------------------------------------------------------- predictor

   // indexes are taken at the moment the field is produced
   task automatic emit_field(input logic [2:0] kind, input logic [63:0] data,
                             input logic [1:0] word, input logic [2:0] err);
      parsed_field_type f;
      f = '{kind, data, word, tx_at, coin_at, err};
      expected_fields = {expected_fields, f};
   endtask

   // any error drops the parser to idle until the next begin
   task automatic abort_record(input logic [2:0] err);
      parse_phase = PH_IDLE;
      emit_field(KIND_ERROR, 64'd0, 2'd0, err);
   endtask

   task automatic begin_field(input logic [3:0] next_phase);
      parse_phase = next_phase;
      field_bytes = '0;
      field_acc = '0;
   endtask

   // little-endian accumulate into the current field
   task automatic shift_byte(input logic [7:0] b);
      field_acc = field_acc | (64'(b) << (8 * field_bytes[2:0]));
      field_bytes = field_bytes + 6'd1;
      bytes_taken = bytes_taken + 32'd1;
   endtask

   task automatic advance_tx();
      tx_at = tx_at + 16'd1;
      coin_at = '0;
      if (tx_at >= tx_count_total)
         begin_field(PH_FIN);
      else
         begin_field(PH_CC);
   endtask

   // work out what one accepted input transaction produces
   task automatic predict_parse(input logic cmd, input logic [7:0] b,
                                input logic [31:0] len);
      logic [63:0] v;
      logic [1:0]  word_idx;
      if (cmd == CMD_BEGIN) begin
         // a begin restarts from scratch whatever was in progress
         record_len = len;
         bytes_taken = '0;
         tx_count_total = '0;
         tx_at = '0;
         coin_count_total = '0;
         coin_at = '0;
         begin_field(PH_TXC);
         if (len < 32'd4)
            abort_record(ERR_TOO_SHORT);
      end else begin
         case (parse_phase)
            PH_TXC: begin
               shift_byte(b);
               if (field_bytes == 6'd4) begin
                  v = field_acc;
                  if (v > 64'(limit_count)) begin
                     abort_record(ERR_TX_COUNT);
                  end else begin
                     tx_count_total = v[15:0];
                     if (tx_count_total == 16'd0)
                        begin_field(PH_FIN);
                     else
                        begin_field(PH_CC);
                     emit_field(KIND_TX_COUNT, v, 2'd0, ERR_NONE);
                  end
               end
            end
            PH_CC: begin
               // the whole count must fit before its first byte is taken
               if (field_bytes == 6'd0 && 64'(bytes_taken) + 64'd4 > 64'(record_len)) begin
                  abort_record(ERR_TRUNC_COUNT);
               end else begin
                  shift_byte(b);
                  if (field_bytes == 6'd4) begin
                     v = field_acc;
                     if (v > 64'(limit_count)) begin
                        abort_record(ERR_COIN_COUNT);
                     end else if (64'(bytes_taken) + v * 64'(COIN_BYTES) > 64'(record_len)) begin
                        abort_record(ERR_TRUNC_COINS);
                     end else begin
                        coin_count_total = v[15:0];
                        coin_at = '0;
                        emit_field(KIND_COIN_COUNT, v, 2'd0, ERR_NONE);
                        if (coin_count_total == 16'd0)
                           advance_tx();
                        else
                           begin_field(PH_VAL);
                     end
                  end
               end
            end
            PH_VAL: begin
               shift_byte(b);
               if (field_bytes == 6'd8) begin
                  v = field_acc;
                  begin_field(PH_HGT);
                  emit_field(KIND_VALUE, v, 2'd0, ERR_NONE);
               end
            end
            PH_HGT: begin
               shift_byte(b);
               if (field_bytes == 6'd4) begin
                  v = field_acc;
                  begin_field(PH_CB);
                  emit_field(KIND_HEIGHT, v, 2'd0, ERR_NONE);
               end
            end
            PH_CB: begin
               bytes_taken = bytes_taken + 32'd1;
               parse_phase = PH_SP;
               field_acc = (b != 8'd0) ? 64'd1 : 64'd0;
            end
            PH_SP: begin
               bytes_taken = bytes_taken + 32'd1;
               v = field_acc | ((b != 8'd0) ? 64'd2 : 64'd0);
               begin_field(PH_HASH);
               emit_field(KIND_FLAGS, v, 2'd0, ERR_NONE);
            end
            PH_HASH: begin
               shift_byte(b);
               if (field_bytes[2:0] == 3'd0) begin
                  word_idx = 2'((field_bytes - 6'd1) >> 3);
                  v = field_acc;
                  field_acc = '0;
                  emit_field(KIND_HASH_WORD, v, word_idx, ERR_NONE);
                  if (field_bytes >= 6'd32) begin
                     coin_at = coin_at + 16'd1;
                     if (coin_at >= coin_count_total)
                        advance_tx();
                     else
                        begin_field(PH_VAL);
                  end
               end
            end
            PH_FIN: begin
               // first trailing byte closes the record
               parse_phase = PH_IDLE;
               emit_field(KIND_DONE, 64'(bytes_taken), 2'd0, ERR_NONE);
            end
            default: ;
         endcase
      end
   endtask

   // ---------------------------------------------------------------- drivers

   // one input transaction; entered and left at a falling edge, valid left high
   task automatic send_item(input logic cmd, input logic [7:0] b, input logic [31:0] len);
      while (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_data_byte <= b;
      req_record_length <= len;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_parse(cmd, b, len);
      items_sent++;
      @(negedge clock);
   endtask

   // stop sending and wait until the parser has nothing left in flight
   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_fields.size() != 0) @(posedge clock);
      // bytes that give no result may still sit in the input queue
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // apb write of max_count; upper data bits are junk on purpose
   task automatic write_max_count(input logic [15:0] value);
      logic [31:0] wdata;
      wdata = {16'($urandom), value};
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {REG_MAX_COUNT, 2'b00};
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      limit_count = wdata[15:0];
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic push_le(input logic [63:0] value, input int nbytes);
      for (int i = 0; i < nbytes; i++)
         record_bytes = {record_bytes, value[8*i +: 8]};
   endtask

   // bytes past the phase budget are dropped so the item count stays close to plan
   task automatic send_record(input logic [31:0] len);
      send_item(CMD_BEGIN, 8'($urandom), len);
      foreach (record_bytes[i])
         if (items_sent < send_limit)
            send_item(CMD_DATA, record_bytes[i], $urandom);
      record_bytes.delete();
   endtask

   // mostly tiny counts, sometimes right at or over the limit, sometimes wild
   function automatic logic [31:0] pick_count();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75)
         return $urandom_range(0, 2);
      else if (r < 85)
         return 32'(limit_count) + $urandom_range(0, 1);
      else if (r < 93)
         return $urandom;
      else
         return 32'h0000_FFFF + $urandom_range(0, 1);
   endfunction

   // one undo record with random content; counts past 3 are cut short on the wire
   task automatic send_random_record();
      logic [31:0] tx_field;
      logic [31:0] coin_field;
      logic [31:0] length;
      int unsigned n_tx;
      int unsigned n_coin;
      int unsigned body;
      int unsigned r;
      int unsigned keep;
      tx_field = pick_count();
      push_le(tx_field, 4);
      n_tx = (tx_field > 32'd3) ? 3 : tx_field;
      for (int t = 0; t < n_tx; t++) begin
         coin_field = pick_count();
         push_le(coin_field, 4);
         n_coin = (coin_field > 32'd3) ? 3 : coin_field;
         for (int c = 0; c < n_coin; c++) begin
            push_le(($urandom_range(0, 9) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                : {$urandom, $urandom}, 8);
            push_le($urandom, 4);
            push_le($urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(1, 255)), 1);
            push_le($urandom_range(0, 1) ? 64'd0 : 64'($urandom_range(1, 255)), 1);
            for (int w = 0; w < 4; w++)
               push_le({$urandom, $urandom}, 8);
         end
      end
      body = record_bytes.size();
      r = $urandom_range(0, 99);
      if (r < 70)
         length = body;
      else if (r < 82)
         length = $urandom_range(0, body);
      else if (r < 90)
         length = $urandom;
      else
         length = body + $urandom_range(1, 200);
      // trailing bytes: the first closes the record, the rest are ignored
      push_le({$urandom, $urandom}, $urandom_range(0, 2));
      // now and then the next begin cuts this record off
      if ($urandom_range(0, 9) == 0) begin
         keep = $urandom_range(0, record_bytes.size());
         while (record_bytes.size() > keep) void'(record_bytes.pop_back());
      end
      // stray byte while the parser is idle or mid record
      if ($urandom_range(0, 9) == 0)
         send_item(CMD_DATA, 8'($urandom), $urandom);
      send_record(length);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at %0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      parsed_field_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (expected_fields.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d data %0h",
                                      rsp_kind, rsp_data));
         end else begin
            want = expected_fields.pop_front();
            if (rsp_kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
            if (rsp_data !== want.data)
               report_mismatch($sformatf("data %0h, want %0h", rsp_data, want.data));
            if (rsp_hash_word_index !== want.word)
               report_mismatch($sformatf("hash word %0d, want %0d",
                                         rsp_hash_word_index, want.word));
            if (rsp_tx_index !== want.tx)
               report_mismatch($sformatf("tx index %0d, want %0d", rsp_tx_index, want.tx));
            if (rsp_coin_index !== want.coin)
               report_mismatch($sformatf("coin index %0d, want %0d",
                                         rsp_coin_index, want.coin));
            if (rsp_error_code !== want.err)
               report_mismatch($sformatf("error code %0d, want %0d",
                                         rsp_error_code, want.err));
         end
      end
   end

   // result side: random stalls, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (hold_cycles != 0) begin
         rsp_ready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(1, 100) > receiver_stall_pct);
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
                            input logic [15:0] limit, input int unsigned budget);
      int unsigned target;
      sender_idle_pct = send_pct;
      receiver_stall_pct = stall_pct;
      write_max_count(limit);
      target = items_sent + budget;
      send_limit = target;
      while (items_sent < target)
         send_random_record();
      send_limit = 32'hFFFF_FFFF;
      drain_block();
   endtask

   task automatic test_directed_cases();
      // byte before any begin is ignored
      send_item(CMD_DATA, 8'h5A, 32'hFFFF_FFFF);
      // lengths under 4 fail at once
      send_item(CMD_BEGIN, 8'hFF, 32'd0);
      send_item(CMD_BEGIN, 8'h00, 32'd3);
      // a begin in the middle of a count abandons it
      push_le(64'hFF, 2);
      send_record(32'd100);
      // empty record: zero transactions, trailing byte gives done, next is ignored
      push_le(64'd0, 4);
      push_le(64'hFFFF, 2);
      send_record(32'd4);
      // all-ones transaction count is over any limit
      push_le(64'hFFFF_FFFF, 4);
      send_record(32'hFFFF_FFFF);
      // one transaction with no coins, then done
      push_le(64'd1, 4);
      push_le(64'd0, 4);
      push_le(64'h80, 1);
      send_record(32'd8);
      // no room for the coin count
      push_le(64'd1, 4);
      push_le(64'h7F, 1);
      send_record(32'd7);
      drain_block();
   endtask

   task automatic test_full_rate();
      run_phase(0, 0, 16'hFFFF, 250);
   endtask

   task automatic test_sender_gaps();
      run_phase(65, 0, 16'd2, 220);
   endtask

   task automatic test_receiver_stalls();
      run_phase(0, 65, 16'd1, 220);
   endtask

   task automatic test_mixed_idling();
      run_phase(38, 38, 16'd3, 220);
   endtask

   task automatic test_zero_limit();
      run_phase(38, 38, 16'd0, 60);
   endtask

   // receiver holds off while the sender keeps pushing, so the input backs up
   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      write_max_count(16'hFFFF);
      @(posedge clock);
      hold_cycles = HOLD_OFF_CYCLES;
      @(negedge clock);
      run_phase(0, 0, 16'hFFFF, 120);
      run_phase(0, 20, 16'hFFFF, 40);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_BEGIN;
      req_data_byte = '0;
      req_record_length = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_full_rate();
      test_sender_gaps();
      test_receiver_stalls();
      test_mixed_idling();
      test_zero_limit();
      test_backpressure();

      if (mismatch_count == 0)
         $display("undo_record_parser verification clean");
      else
         $display("undo_record_parser verification failed");
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #600000;
      $display("undo_record_parser verification failed");
      $finish;
   end

endmodule
